// ----- rtl/gepe_pkg.sv -----
// ----------------------------------------------------------------------------
// GF(2^8) erasure parity encoder package
// Shared widths, codes, the stage control type and the field multiplier.
// ----------------------------------------------------------------------------
package gepe_pkg;

    // Default sizing of the coefficient store and the accumulator lanes
    localparam int DEF_MAX_SOURCES = 32;
    localparam int DEF_MAX_ROWS    = 8;

    // Fixed field widths of the stream and register interfaces
    localparam int SRC_W       = 5;
    localparam int ROW_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;
    localparam int NSRC_REG_W  = 6;
    localparam int NROW_REG_W  = 4;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 1;

    // Low part of the field polynomial x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1d;

    // Operation codes carried in tuser
    localparam logic OP_COEF = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_SOURCES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS    = 1'b1;

    // Control of a data byte travelling from the read stage to the MAC stage
    typedef struct packed {
        logic valid;
        logic close;
    } t_s1_ctrl;

    // Shift-and-add multiply in GF(2^8)
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] p;
        x = a;
        p = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i]) begin
                p = p ^ x;
            end
            x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LOW : '0);
        end
        return p;
    endfunction

endpackage

// ----- rtl/gepe_coef_mem.sv -----
// ----------------------------------------------------------------------------
// Coefficient memory
// One bank per row, addressed by source; all banks are read in parallel.
// ----------------------------------------------------------------------------
module gepe_coef_mem #(
    parameter int MAX_SOURCES = gepe_pkg::DEF_MAX_SOURCES,
    parameter int MAX_ROWS    = gepe_pkg::DEF_MAX_ROWS,
    parameter int ADDR_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [gepe_pkg::ROW_W-1:0]    i_wr_row,
    input  logic [ADDR_W-1:0]             i_wr_addr,
    input  logic [gepe_pkg::BYTE_W-1:0]   i_wdata,
    input  logic                          i_rd_en,
    input  logic [ADDR_W-1:0]             i_rd_addr,
    output logic [gepe_pkg::BYTE_W-1:0]   o_rdata [MAX_ROWS]
);
    import gepe_pkg::*;

    logic [BYTE_W-1:0] r_mem  [MAX_ROWS][MAX_SOURCES];
    logic [BYTE_W-1:0] r_rdata [MAX_ROWS];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < MAX_ROWS; b++) begin
            if (i_we && (32'(i_wr_row) == 32'(b))) begin
                r_mem[b][i_wr_addr] <= i_wdata;
            end
        end
    end

    // Read data is held while the MAC stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            for (int b = 0; b < MAX_ROWS; b++) begin
                r_rdata[b] <= r_mem[b][i_rd_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gepe_mac.sv -----
// ----------------------------------------------------------------------------
// Multiply-accumulate stage
// Multiplies a data byte by each active row's coefficient and folds it into the
// per-row accumulators; a closing byte hands the column to the output buffer.
// ----------------------------------------------------------------------------
module gepe_mac #(
    parameter int MAX_ROWS = gepe_pkg::DEF_MAX_ROWS,
    parameter int ROWS_W   = $clog2(MAX_ROWS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  gepe_pkg::t_s1_ctrl            i_s0,
    input  logic [gepe_pkg::BYTE_W-1:0]   i_val,
    input  logic [gepe_pkg::BYTE_W-1:0]   i_coef [MAX_ROWS],
    input  logic [ROWS_W-1:0]             i_rows,
    output logic                          o_need_buf,
    output logic [gepe_pkg::BYTE_W-1:0]   o_acc_next [MAX_ROWS]
);
    import gepe_pkg::*;

    t_s1_ctrl          r_s1;
    logic [BYTE_W-1:0] r_val;
    logic [BYTE_W-1:0] r_acc [MAX_ROWS];
    logic [BYTE_W-1:0] n_acc [MAX_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (i_adv) begin
            r_s1 <= i_s0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_val <= i_val;
        end
    end

    // Rows at or above the active count keep their value untouched.
    always_comb begin
        for (int r = 0; r < MAX_ROWS; r++) begin
            if (32'(r) < 32'(i_rows)) begin
                n_acc[r] = r_acc[r] ^ gf_mul(r_val, i_coef[r]);
            end else begin
                n_acc[r] = r_acc[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                r_acc[r] <= '0;
            end
        end else if (i_adv && r_s1.valid) begin
            for (int r = 0; r < MAX_ROWS; r++) begin
                r_acc[r] <= r_s1.close ? '0 : n_acc[r];
            end
        end
    end

    assign o_need_buf = r_s1.valid && r_s1.close && (i_rows != '0);
    assign o_acc_next = n_acc;

endmodule

// ----- rtl/gepe_out_buf.sv -----
// ----------------------------------------------------------------------------
// Output buffer
// Holds one finished column and shifts its parity bytes out one per
// transaction, tagging each with its row and the last one with tlast.
// ----------------------------------------------------------------------------
module gepe_out_buf #(
    parameter int MAX_ROWS = gepe_pkg::DEF_MAX_ROWS,
    parameter int ROWS_W   = $clog2(MAX_ROWS + 1),
    parameter int RIDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  logic [ROWS_W-1:0]                i_rows,
    input  logic [gepe_pkg::BYTE_W-1:0]      i_acc [MAX_ROWS],
    output logic                             o_free,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gepe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);
    import gepe_pkg::*;

    logic [BYTE_W-1:0] r_buf [MAX_ROWS];
    logic [ROWS_W-1:0] r_left;
    logic [RIDX_W-1:0] r_row;
    logic              w_take;

    assign w_take = m_axis_tvalid && m_axis_tready;

    // The buffer can take a new column in the cycle its last byte leaves.
    assign o_free = (r_left == '0) || (w_take && (r_left == ROWS_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_row  <= '0;
        end else if (i_load) begin
            r_left <= i_rows;
            r_row  <= '0;
        end else if (w_take) begin
            r_left <= r_left - ROWS_W'(1);
            r_row  <= r_row + RIDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_acc;
        end else if (w_take) begin
            for (int i = 0; i < MAX_ROWS - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    assign m_axis_tvalid = (r_left != '0);
    assign m_axis_tlast  = (r_left == ROWS_W'(1));
    assign m_axis_tdata  = {(OUT_DATA_W - BYTE_W - ROW_W)'(0), ROW_W'(r_row), r_buf[0]};

endmodule

// ----- rtl/gf256_erasure_parity_encoder_top.sv -----
// ----------------------------------------------------------------------------
// GF(2^8) erasure parity encoder, top level
// Coefficient memory, multiply-accumulate stage and output buffer.
//
//   Channel   Direction  Contents (lowest bit first)
//   s_axis    in         tdata: src_index[4:0], row_index[7:5], value[15:8]
//                        tuser: op (0 coefficient, 1 data byte)
//   m_axis    out        tdata: parity_byte[7:0], row_number[10:8], zero pad
//                        tlast: final row of a column
//   i_cfg     in         index 0 num_sources, index 1 num_rows
//
// One input transaction is taken per cycle unless the MAC stage is stalled.
// A data byte reads all row banks of the coefficient memory into a register
// and is accumulated from there once the MAC stage advances. A closing byte
// waits in the MAC stage while the output buffer still holds an earlier column.
// Reset clears the accumulators and control; the coefficient memory is not
// cleared and must be written before use.
// ----------------------------------------------------------------------------
module gf256_erasure_parity_encoder_top #(
    parameter int MAX_SOURCES = gepe_pkg::DEF_MAX_SOURCES,
    parameter int MAX_ROWS    = gepe_pkg::DEF_MAX_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port
    input  logic                             i_cfg_we,
    input  logic [gepe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gepe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gepe_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // src_index, row_index, value
    input  logic [0:0]                       s_axis_tuser,  // op
    // Output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gepe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // parity_byte, row_number
    output logic                             m_axis_tlast
);
    import gepe_pkg::*;

    localparam int ADDR_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int SRCS_W = $clog2(MAX_SOURCES + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    logic [NSRC_REG_W-1:0] r_num_sources;
    logic [NROW_REG_W-1:0] r_num_rows;
    logic [SRCS_W-1:0]     w_srcs;
    logic [ROWS_W-1:0]     w_rows;

    logic                  w_in_acc;
    logic                  w_op;
    logic [SRC_W-1:0]      w_src;
    logic [ROW_W-1:0]      w_row;
    logic [BYTE_W-1:0]     w_val;
    logic                  w_coef_we;
    t_s1_ctrl              w_s0;

    logic                  w_adv;
    logic                  w_need_buf;
    logic                  w_buf_free;
    logic [BYTE_W-1:0]     w_coef [MAX_ROWS];
    logic [BYTE_W-1:0]     w_acc_next [MAX_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sources <= NSRC_REG_W'(1);
            r_num_rows    <= NROW_REG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NUM_SOURCES: r_num_sources <= i_cfg_wdata[NSRC_REG_W-1:0];
                REG_NUM_ROWS:    r_num_rows    <= i_cfg_wdata[NROW_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register values above the built sizes act as the built sizes.
    assign w_srcs = (32'(r_num_sources) > 32'(MAX_SOURCES)) ? SRCS_W'(MAX_SOURCES)
                                                            : SRCS_W'(r_num_sources);
    assign w_rows = (32'(r_num_rows) > 32'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                      : ROWS_W'(r_num_rows);

    assign w_op  = s_axis_tuser[0];
    assign w_src = s_axis_tdata[SRC_W-1:0];
    assign w_row = s_axis_tdata[SRC_W+ROW_W-1:SRC_W];
    assign w_val = s_axis_tdata[SRC_W+ROW_W+BYTE_W-1:SRC_W+ROW_W];

    assign w_adv         = !w_need_buf || w_buf_free;
    assign s_axis_tready = w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_coef_we = w_in_acc && (w_op == OP_COEF) && (32'(w_src) < 32'(MAX_SOURCES))
                       && (32'(w_row) < 32'(MAX_ROWS));

    // Bytes from sources outside the column are dropped here.
    assign w_s0.valid = w_in_acc && (w_op == OP_DATA) && (32'(w_src) < 32'(w_srcs));
    assign w_s0.close = (32'(w_src) + 32'd1) == 32'(w_srcs);

    gepe_coef_mem #(
        .MAX_SOURCES (MAX_SOURCES),
        .MAX_ROWS    (MAX_ROWS),
        .ADDR_W      (ADDR_W)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_we      (w_coef_we),
        .i_wr_row  (w_row),
        .i_wr_addr (ADDR_W'(w_src)),
        .i_wdata   (w_val),
        .i_rd_en   (w_adv),
        .i_rd_addr (ADDR_W'(w_src)),
        .o_rdata   (w_coef)
    );

    gepe_mac #(
        .MAX_ROWS (MAX_ROWS),
        .ROWS_W   (ROWS_W)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_s0       (w_s0),
        .i_val      (w_val),
        .i_coef     (w_coef),
        .i_rows     (w_rows),
        .o_need_buf (w_need_buf),
        .o_acc_next (w_acc_next)
    );

    gepe_out_buf #(
        .MAX_ROWS (MAX_ROWS),
        .ROWS_W   (ROWS_W)
    ) u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_need_buf && w_adv),
        .i_rows        (w_rows),
        .i_acc         (w_acc_next),
        .o_free        (w_buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the GF(2^8) erasure parity encoder
// Fills the coefficient memory, runs a directed set of columns and register
// settings, then random columns under random backpressure on both streams.
// A scoreboard predicts every parity byte and checks each output transaction.
// ----------------------------------------------------------------------------
module tb_top;

    import gepe_pkg::*;

    localparam int SRC_DEPTH = DEF_MAX_SOURCES;
    localparam int ROW_DEPTH = DEF_MAX_ROWS;

    typedef struct packed {
        logic [BYTE_W-1:0] parity;
        logic [ROW_W-1:0]  row;
        logic              last;
    } t_parity_result;

    // Predicts the parity stream from accepted input transactions.
    class parity_scoreboard;
        logic [BYTE_W-1:0]     coef [ROW_DEPTH][SRC_DEPTH];
        logic [BYTE_W-1:0]     accum [ROW_DEPTH];
        logic [NSRC_REG_W-1:0] nsrc_reg;
        logic [NROW_REG_W-1:0] nrow_reg;
        t_parity_result        parity_q [$];
        int                    errors;

        function new();
            foreach (coef[r, s]) coef[r][s] = '0;
            foreach (accum[r]) accum[r] = '0;
            nsrc_reg = 1;
            nrow_reg = 1;
            errors   = 0;
        endfunction

        // Multiply by repeated doubling, most significant bit of b first.
        function logic [BYTE_W-1:0] gf_product(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] p;
            p = '0;
            for (int i = BYTE_W - 1; i >= 0; i--) begin
                p = {p[BYTE_W-2:0], 1'b0} ^ (p[BYTE_W-1] ? GF_POLY_LOW : 8'h00);
                if (b[i]) begin
                    p = p ^ a;
                end
            end
            return p;
        endfunction

        function int active_sources();
            return (nsrc_reg > SRC_DEPTH) ? SRC_DEPTH : int'(nsrc_reg);
        endfunction

        function int active_rows();
            return (nrow_reg > ROW_DEPTH) ? ROW_DEPTH : int'(nrow_reg);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_NUM_SOURCES) begin
                nsrc_reg = val[NSRC_REG_W-1:0];
            end else begin
                nrow_reg = val[NROW_REG_W-1:0];
            end
        endfunction

        // Returns 1 when the transaction had any effect on the block.
        function bit note_input(logic op, logic [SRC_W-1:0] src, logic [ROW_W-1:0] row,
                                logic [BYTE_W-1:0] val);
            int             srcs;
            int             rows;
            t_parity_result res;
            srcs = active_sources();
            rows = active_rows();
            if (op == OP_COEF) begin
                coef[row][src] = val;
                return 1'b1;
            end
            if (int'(src) >= srcs) begin
                return 1'b0;
            end
            for (int r = 0; r < rows; r++) begin
                accum[r] = accum[r] ^ gf_product(val, coef[r][src]);
            end
            if (int'(src) + 1 == srcs) begin
                for (int r = 0; r < rows; r++) begin
                    res.parity = accum[r];
                    res.row    = r[ROW_W-1:0];
                    res.last   = (r + 1 == rows);
                    parity_q   = {parity_q, res};
                end
                foreach (accum[r]) accum[r] = '0;
            end
            return 1'b1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic last);
            t_parity_result want;
            if (parity_q.size() == 0) begin
                report($sformatf("unexpected output transaction tdata=%h tlast=%b", data, last));
            end else begin
                want = parity_q.pop_front();
                if (data[BYTE_W-1:0] !== want.parity) begin
                    report($sformatf("row %0d parity got %h want %h",
                                     want.row, data[BYTE_W-1:0], want.parity));
                end
                if (data[BYTE_W+ROW_W-1:BYTE_W] !== want.row) begin
                    report($sformatf("row number got %0d want %0d",
                                     data[BYTE_W+ROW_W-1:BYTE_W], want.row));
                end
                if (data[OUT_DATA_W-1:BYTE_W+ROW_W] !== '0) begin
                    report($sformatf("tdata padding not zero: %h", data));
                end
                if (last !== want.last) begin
                    report($sformatf("row %0d tlast got %b want %b", want.row, last, want.last));
                end
            end
        endtask

        task check_drained();
            if (parity_q.size() != 0) begin
                report($sformatf("%0d parity bytes never arrived", parity_q.size()));
            end
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;   // src_index, row_index, value
    logic [0:0]              s_axis_tuser = '0;   // op
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;        // parity_byte, row_number
    logic                    m_axis_tlast;

    parity_scoreboard sb = new();

    bit tx_burst      = 1'b0;
    bit long_hold_req = 1'b0;
    int counted_items = 0;

    gf256_erasure_parity_encoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function int pick_gap();
        int r;
        if (tx_burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // tvalid stays high so that a back-to-back transaction needs no new edge.
    task automatic send_item(logic op, logic [SRC_W-1:0] src, logic [ROW_W-1:0] row,
                             logic [BYTE_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, row, src};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        void'(sb.note_input(op, src, row, val));
        counted_items++;
    endtask

    task automatic send_data(logic [SRC_W-1:0] src, logic [BYTE_W-1:0] val);
        send_item(OP_DATA, src, ROW_W'($urandom), val);
    endtask

    // Lowers tvalid, waits for every parity byte and lets the pipeline drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.parity_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        sb.set_reg(idx, CFG_DATA_W'(val));
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_shape(int nsrc, int nrow);
        write_reg(REG_NUM_SOURCES, nsrc);
        write_reg(REG_NUM_ROWS, nrow);
    endtask

    // Output side: checks each transaction and plays a random tready pattern.
    initial begin
        int  rx_left;
        bit  rx_level;
        int  r;
        rx_left  = 0;
        rx_level = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rx_level      = 1'b0;
                rx_left       = 300;
            end else if (rx_left > 0) begin
                rx_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(1, 20);
                end else if (r < 80) begin
                    rx_level = 1'b0;
                    rx_left  = $urandom_range(1, 3);
                end else if (r < 95) begin
                    rx_level = 1'b0;
                    rx_left  = $urandom_range(4, 10);
                end else if (r < 99) begin
                    rx_level = 1'b1;
                    rx_left  = $urandom_range(30, 80);
                end else begin
                    rx_level = 1'b0;
                    rx_left  = $urandom_range(20, 60);
                end
            end
            m_axis_tready <= rx_level;
        end
    end

    initial begin
        int nsrc;
        int nrow;
        int srcs;
        int ncols;
        int nnoise;
        int r;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // The coefficient memory has no reset, so every entry is written first.
        for (int row = 0; row < ROW_DEPTH; row++) begin
            for (int src = 0; src < SRC_DEPTH; src++) begin
                send_item(OP_COEF, SRC_W'(src), ROW_W'(row), BYTE_W'($urandom));
            end
        end

        // Reset shape: one source, one row.
        send_item(OP_COEF, 5'd0, 3'd0, 8'hff);
        send_data(5'd0, 8'hff);
        send_data(5'd0, 8'h00);
        send_item(OP_COEF, 5'd0, 3'd0, 8'h00);
        send_data(5'd0, 8'hff);
        send_item(OP_COEF, 5'd0, 3'd0, 8'h80);
        send_data(5'd0, 8'h80);

        // Out of order and repeated sources, an ignored source and a
        // coefficient write in the middle of a column.
        set_shape(3, 8);
        send_data(5'd1, 8'h5a);
        send_data(5'd0, 8'hc3);
        send_data(5'd1, 8'h01);
        send_data(5'd5, 8'h77);
        send_item(OP_COEF, 5'd2, 3'd7, 8'h1d);
        send_data(5'd2, 8'hfe);

        // With no sources every data byte is dropped.
        write_reg(REG_NUM_SOURCES, 0);
        send_data(5'd0, 8'h12);
        send_data(5'd31, 8'h34);

        // With no rows the column closes silently and still clears the sums.
        set_shape(2, 0);
        send_data(5'd0, 8'hab);
        send_data(5'd1, 8'hcd);
        write_reg(REG_NUM_ROWS, 1);
        send_data(5'd1, 8'hef);

        // A register write in the middle of a column keeps the partial sums.
        set_shape(2, 2);
        send_data(5'd0, 8'h9c);
        write_reg(REG_NUM_ROWS, 4);
        send_data(5'd1, 8'h63);

        // Oversized registers saturate at the memory dimensions.
        set_shape(40, 12);
        send_data(5'd31, 8'h3e);
        set_shape(63, 15);
        send_data(5'd30, 8'hd1);
        send_data(5'd31, 8'h2f);

        // The receiver holds off for a long stretch while bytes keep coming.
        set_shape(1, 8);
        tx_burst      = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 80; i++) begin
            send_data(5'd0, BYTE_W'($urandom));
        end
        tx_burst = 1'b0;
        settle();

        while (counted_items < 500) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                nsrc = $urandom_range(1, 8);
            end else if (r < 80) begin
                nsrc = SRC_DEPTH;
            end else if (r < 90) begin
                nsrc = $urandom_range(9, 31);
            end else if (r < 95) begin
                nsrc = 0;
            end else begin
                nsrc = $urandom_range(33, 63);
            end
            r = $urandom_range(0, 99);
            if (r < 85) begin
                nrow = $urandom_range(1, 8);
            end else if (r < 92) begin
                nrow = 0;
            end else begin
                nrow = $urandom_range(9, 15);
            end
            set_shape(nsrc, nrow);
            srcs     = sb.active_sources();
            tx_burst = ($urandom_range(0, 3) == 0);
            ncols    = (srcs >= 16) ? $urandom_range(1, 2) : $urandom_range(3, 10);

            for (int col = 0; col < ncols; col++) begin
                if (srcs > 0 && $urandom_range(0, 9) < 8) begin
                    for (int s = 0; s < srcs; s++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_item(OP_COEF, SRC_W'($urandom), ROW_W'($urandom),
                                      BYTE_W'($urandom));
                        end
                        send_data(SRC_W'(s), BYTE_W'($urandom));
                    end
                end else begin
                    nnoise = $urandom_range(1, 2 * srcs + 2);
                    for (int i = 0; i < nnoise; i++) begin
                        if ($urandom_range(0, 4) == 0) begin
                            send_item(OP_COEF, SRC_W'($urandom), ROW_W'($urandom),
                                      BYTE_W'($urandom));
                        end else if ($urandom_range(0, 1) == 0 && srcs > 0) begin
                            send_data(SRC_W'($urandom_range(0, srcs - 1)), BYTE_W'($urandom));
                        end else begin
                            send_data(SRC_W'($urandom), BYTE_W'($urandom));
                        end
                    end
                end
            end
            tx_burst = 1'b0;
        end

        settle();
        repeat (32) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/gepe_pkg.sv
rtl/gepe_coef_mem.sv
rtl/gepe_mac.sv
rtl/gepe_out_buf.sv
rtl/gf256_erasure_parity_encoder_top.sv
test/tb_top.sv
